[rtl/core/srq_pkg.sv]
// Package for the sorted ready queue: entry and beat types, op codes, sizes and states.
// No dependencies.
`default_nettype none
package srq_pkg;
  localparam int QueueDepth = 16;
  localparam int AddrW = $clog2(QueueDepth);
  localparam int CountW = $clog2(QueueDepth + 1);

  typedef enum logic [3:0] {
    OP_APPEND = 4'd0, OP_PREPEND = 4'd1, OP_TAKE_HEAD = 4'd2,
    OP_TAKE_TAIL = 4'd3, OP_CLEAR = 4'd4, OP_SORT_INS = 4'd5,
    OP_REMOVE = 4'd6, OP_READ = 4'd7, OP_SHORTEST = 4'd8
  } op_t;

  typedef struct packed {
    logic [7:0] id;
    logic [15:0] tau;
    logic [31:0] pay;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic [3:0] op;
    entry_t ne;
    logic [AddrW-1:0] position;
  } in_beat_t;

  typedef struct packed {
    entry_t res;
    logic entry_valid;
    logic [CountW-1:0] queue_count;
    logic queue_empty;
    logic op_error;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECODE, ST_FETCH, ST_WALK, ST_SORT_LOAD, ST_SORT_HOLD,
    ST_SORT_CMP, ST_SORT_PLACE, ST_DONE
  } state_t;

  function automatic logic key_less(entry_t a, entry_t b);
    if (a.tau != b.tau) begin
      return a.tau < b.tau;
    end
    return a.id < b.id;
  endfunction
endpackage
`default_nettype wire

[rtl/core/srq_if.sv]
// Valid/ready channel interface with a generic payload type.
// Depends on nothing.
`default_nettype none
interface srq_if #(parameter type payload_t = logic);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/srq_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module srq_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input wire logic clk,
  input wire logic we,
  input wire logic [$clog2(Depth)-1:0] waddr,
  input wire logic [Width-1:0] wdata,
  input wire logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[rtl/core/sorted_ready_queue_unit.sv]
// Sorted ready queue top level: op sequencer around one entry RAM.
// Depends on srq_pkg, srq_if and srq_ram.
//
// One op beat enters on in_ch and exactly one result beat leaves on out_ch.
// The block takes one op at a time; in_ch.ready is high only while idle.
// The entry RAM has one read and one write port with a registered read,
// so every walk over the stored entries moves one entry per cycle.
// Push back, clear, unused codes and any refused op go from decode straight
// to the result; pop back and read fetch one entry; push front, pop front,
// remove and shortest walk over the entries held before the op. Sorted
// insert appends the entry and then, unless the queue was empty, runs an
// insertion sort over the RAM. The result beat is held in registers; while
// the receiver stalls it stays on out_ch and no new op is taken. After reset
// the queue is empty and in_ch is ready.
`default_nettype none
module sorted_ready_queue_unit (
  input wire logic clk,
  input wire logic rst,
  srq_if.sink in_ch,
  srq_if.source out_ch
);
  import srq_pkg::*;

  state_t state, state_next;
  logic [3:0] op;
  entry_t ne;
  logic [AddrW-1:0] pos;
  logic [CountW-1:0] count, count_next;
  logic [CountW-1:0] i, i_next, j, j_next, k, k_next;
  entry_t hold, hold_next;
  entry_t res, res_next;
  logic res_valid, res_valid_next;
  logic err, err_next;
  logic we;
  logic [AddrW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic [EntryW-1:0] rdata_raw;
  logic in_fire, out_fire;
  logic queue_full, walk_last, sort_last, hold_less, keep;
  logic [CountW-1:0] tail, i_dec, i_inc, i_back2, j_back2;
  out_beat_t result;

  srq_ram #(.Width(EntryW), .Depth(QueueDepth)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata_raw)
  );
  assign rdata = entry_t'(rdata_raw);

  assign in_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_DONE);
  assign in_fire = in_ch.valid && (state == ST_IDLE);
  assign out_fire = out_ch.ready && (state == ST_DONE);

  assign queue_full = (count == CountW'(QueueDepth));
  assign walk_last = (i == count);
  assign sort_last = (i_inc == count);
  assign hold_less = key_less(hold, rdata);
  assign keep = (rdata.id != ne.id);
  assign tail = count - 1'b1;
  assign i_dec = i - 1'b1;
  assign i_inc = i + 1'b1;
  assign i_back2 = i - CountW'(2);
  assign j_back2 = j - CountW'(2);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_fire) state_next = ST_DECODE;
      ST_DECODE: begin
        state_next = ST_DONE;
        case (op)
          OP_PREPEND: if (!queue_full && count != '0) state_next = ST_WALK;
          OP_TAKE_HEAD, OP_REMOVE, OP_SHORTEST: if (count != '0) state_next = ST_WALK;
          OP_TAKE_TAIL: if (count != '0) state_next = ST_FETCH;
          OP_READ: if ({1'b0, pos} < count) state_next = ST_FETCH;
          OP_SORT_INS: if (!queue_full && count != '0) state_next = ST_SORT_LOAD;
          default: state_next = ST_DONE;
        endcase
      end
      ST_FETCH: state_next = ST_DONE;
      ST_WALK: if (walk_last) state_next = ST_DONE;
      ST_SORT_LOAD: state_next = ST_SORT_HOLD;
      ST_SORT_HOLD: state_next = ST_SORT_CMP;
      ST_SORT_CMP: begin
        if (hold_less) begin
          if (j == CountW'(1)) state_next = ST_SORT_PLACE;
        end else if (sort_last) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_SORT_HOLD;
        end
      end
      ST_SORT_PLACE: state_next = sort_last ? ST_DONE : ST_SORT_HOLD;
      ST_DONE: if (out_fire) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    count_next = count;
    i_next = i;
    j_next = j;
    k_next = k;
    hold_next = hold;
    res_next = res;
    res_valid_next = res_valid;
    err_next = err;
    we = 1'b0;
    waddr = '0;
    wdata = ne;
    raddr = i[AddrW-1:0];
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          res_next = '0;
          res_valid_next = 1'b0;
          err_next = 1'b0;
        end
      end
      ST_DECODE: begin
        i_next = CountW'(1);
        k_next = '0;
        raddr = '0;
        case (op)
          OP_APPEND, OP_SORT_INS: begin
            if (queue_full) begin
              err_next = 1'b1;
            end else begin
              we = 1'b1;
              waddr = count[AddrW-1:0];
              count_next = count + 1'b1;
            end
          end
          OP_PREPEND: begin
            if (queue_full) begin
              err_next = 1'b1;
            end else begin
              we = 1'b1;
              if (count == '0) count_next = CountW'(1);
            end
          end
          OP_TAKE_HEAD, OP_SHORTEST: if (count == '0) err_next = 1'b1;
          OP_TAKE_TAIL: begin
            if (count == '0) begin
              err_next = 1'b1;
            end else begin
              raddr = tail[AddrW-1:0];
              count_next = tail;
            end
          end
          OP_READ: begin
            if ({1'b0, pos} >= count) err_next = 1'b1;
            else raddr = pos;
          end
          OP_CLEAR: count_next = '0;
          default: ;
        endcase
      end
      ST_FETCH: begin
        res_next = rdata;
        res_valid_next = 1'b1;
      end
      ST_WALK: begin
        if (!walk_last) i_next = i_inc;
        case (op)
          OP_PREPEND: begin
            we = 1'b1;
            waddr = i[AddrW-1:0];
            wdata = rdata;
            if (walk_last) count_next = count + 1'b1;
          end
          OP_TAKE_HEAD: begin
            if (i == CountW'(1)) begin
              res_next = rdata;
              res_valid_next = 1'b1;
            end else begin
              we = 1'b1;
              waddr = i_back2[AddrW-1:0];
              wdata = rdata;
            end
            if (walk_last) count_next = tail;
          end
          OP_REMOVE: begin
            if (keep) begin
              we = 1'b1;
              waddr = k[AddrW-1:0];
              wdata = rdata;
              k_next = k + 1'b1;
            end
            if (walk_last) count_next = keep ? k + 1'b1 : k;
          end
          default: begin
            if (i == CountW'(1) || rdata.tau < res.tau) res_next = rdata;
            res_valid_next = 1'b1;
          end
        endcase
      end
      ST_SORT_HOLD: begin
        hold_next = rdata;
        j_next = i;
        raddr = i_dec[AddrW-1:0];
      end
      ST_SORT_CMP: begin
        we = 1'b1;
        waddr = j[AddrW-1:0];
        if (hold_less) begin
          wdata = rdata;
          j_next = j - 1'b1;
          raddr = j_back2[AddrW-1:0];
        end else begin
          wdata = hold;
          i_next = i_inc;
          raddr = i_inc[AddrW-1:0];
        end
      end
      ST_SORT_PLACE: begin
        we = 1'b1;
        waddr = '0;
        wdata = hold;
        i_next = i_inc;
        raddr = i_inc[AddrW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
      op <= '0;
      ne <= '0;
      pos <= '0;
      i <= '0;
      j <= '0;
      k <= '0;
      hold <= '0;
      res <= '0;
      res_valid <= 1'b0;
      err <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      i <= i_next;
      j <= j_next;
      k <= k_next;
      hold <= hold_next;
      res <= res_next;
      res_valid <= res_valid_next;
      err <= err_next;
      if (in_fire) begin
        op <= in_ch.data.op;
        ne <= in_ch.data.ne;
        pos <= in_ch.data.position;
      end
    end
  end

  always_comb begin
    result.res = res;
    result.entry_valid = res_valid;
    result.queue_count = count;
    result.queue_empty = (count == '0);
    result.op_error = err;
  end

  assign out_ch.data = result;
endmodule
`default_nettype wire
